// ===== src/pidt_pkg.sv =====
//------------------------------------------------------------------------------
// pidt_pkg
// shared types and codes for the process id table allocator
//------------------------------------------------------------------------------
`default_nettype none
package pidt_pkg;
  typedef enum logic [2:0] {
    CMD_ALLOC, CMD_UNALLOC, CMD_DETACH, CMD_EXIT,
    CMD_JOIN, CMD_SETFLAG, CMD_GETFLAG, CMD_PTEST
  } cmd_t;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOSUCH = 3'd2;
  localparam logic [2:0] ST_INVAL = 3'd3;
  localparam logic [2:0] ST_SELF = 3'd4;
  localparam logic [2:0] ST_PEND = 3'd5;
  localparam logic [14:0] ID_NONE = 15'd0;
  localparam logic [14:0] ID_BOOT = 15'd1;
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_EVAL1, S_RD2, S_EVAL2,
    S_PROBE, S_PWAIT, S_WALK, S_WWAIT, S_WFIN, S_WFWAIT, S_OUT
  } state_t;
  typedef struct packed {
    logic        used;
    logic [14:0] id;
    logic [14:0] parent;
    logic        exited;
    logic [7:0]  flag;
  } slot_t;
endpackage
`default_nettype wire

// ===== src/process_id_table_allocator_top.sv =====
//------------------------------------------------------------------------------
// process_id_table_allocator_top
// process id slot table with alloc, free, detach, exit walk, join, flag and parent test commands
//------------------------------------------------------------------------------
// One command word in, one result word out. The slot table and the exit status
// words live in two synchronous RAMs that share one write address and one read
// address, so each command walks a sequence of states; alloc reads and tests one
// occupied slot after another until it finds a free one, and exit sweeps every slot
// once. After reset a clearing pass writes every slot before the first command is taken.
`default_nettype none
module process_id_table_allocator_top
  import pidt_pkg::*;
#(
  parameter int SLOTS = 128,
  parameter int ID_FIRST = 2,
  parameter int ID_LAST = 32767
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         cmd,
  input  wire logic [14:0]        caller_pid,
  input  wire logic [14:0]        target_pid,
  input  wire logic [14:0]        other_pid,
  input  wire logic signed [31:0] value,
  input  wire logic               detach_children,
  input  wire logic               no_hang,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [14:0]             result_pid,
  output logic signed [31:0]      result_value
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [15:0] IDF = 16'(ID_FIRST);
  localparam logic [15:0] IDL = 16'(ID_LAST);
  localparam logic [15:0] SPAN = 16'(ID_LAST - ID_FIRST + 1);
  localparam logic [AW-1:0] BOOT_A = AW'(1 % SLOTS);

  slot_t       mem [SLOTS];
  logic [31:0] smem [SLOTS];
  slot_t       rd;
  logic [31:0] rd_st;
  logic        we, swe;
  logic [AW-1:0] wa, ra;
  slot_t       wd;
  logic [31:0] swd;

  state_t state, state_next;
  cmd_t   c;
  logic [14:0] caller, target, other;
  logic [31:0] val;
  logic dk, nh;
  logic [2:0] st;
  logic [14:0] rpid;
  logic [31:0] rval;
  logic [14:0] cand;
  logic [15:0] probes;
  logic [CW-1:0] live;
  logic [AW:0] ptr;

  function automatic logic [AW-1:0] slot_of(input logic [14:0] p);
    return AW'({17'd0, p} % SLOTS);
  endfunction
  function automatic logic rng(input logic [14:0] p);
    return {1'b0, p} >= IDF && {1'b0, p} <= IDL;
  endfunction
  function automatic logic [14:0] adv(input logic [14:0] p);
    return ({1'b0, p} + 16'd1 > IDL) ? IDF[14:0] : p + 15'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (swe) smem[wa] <= swd;
    rd <= mem[ra];
    rd_st <= smem[ra];
  end

  logic found;
  assign found = rd.used && rd.id == (c == CMD_EXIT ? caller : target);

  logic [2:0] st_n;
  logic [14:0] rpid_n, cand_n;
  logic [31:0] rval_n;
  logic [CW-1:0] live_n;
  logic [AW:0] ptr_n;
  logic [15:0] probes_n;
  slot_t freed;

  always_comb begin
    freed = '0;
    state_next = state;
    we = 1'b0; swe = 1'b0; wa = '0; wd = rd; swd = '0;
    ra = slot_of(target);
    st_n = st; rpid_n = rpid; rval_n = rval; cand_n = cand; live_n = live;
    ptr_n = ptr; probes_n = probes;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; swe = 1'b1; wa = ptr[AW-1:0];
        wd = '0;
        if (ptr[AW-1:0] == BOOT_A) begin
          wd.used = 1'b1; wd.id = ID_BOOT;
        end
        ptr_n = ptr + 1'b1;
        if (ptr == (AW+1)'(SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        st_n = ST_OK; rpid_n = '0; rval_n = '0;
        if (in_valid) begin
          if (cmd_t'(cmd) == CMD_ALLOC) begin
            if (live >= CW'(SLOTS)) begin
              st_n = ST_FULL; state_next = S_OUT;
            end else begin
              probes_n = '0; state_next = S_PROBE;
            end
          end else state_next = S_RD1;
        end
      end
      S_RD1: begin
        ra = (c == CMD_EXIT) ? slot_of(caller) : slot_of(target);
        state_next = S_EVAL1;
      end
      S_EVAL1: begin
        wa = (c == CMD_EXIT) ? slot_of(caller) : slot_of(target);
        state_next = S_OUT;
        unique case (c)
          CMD_UNALLOC: begin
            if (!rng(target)) st_n = ST_INVAL;
            else if (!found) st_n = ST_NOSUCH;
            else if (rd.exited || rd.parent != caller) st_n = ST_INVAL;
            else begin
              we = 1'b1; wd = freed; live_n = live - 1'b1;
            end
          end
          CMD_DETACH: begin
            if (!found) st_n = ST_NOSUCH;
            else if (rd.parent == ID_NONE || rd.parent != caller ||
                     target == ID_NONE || target == ID_BOOT) st_n = ST_INVAL;
            else if (rd.exited) begin
              we = 1'b1; wd = freed; live_n = live - 1'b1;
            end else begin
              we = 1'b1; wd.parent = ID_NONE;
            end
          end
          CMD_EXIT: begin
            if (!found) st_n = ST_NOSUCH;
            else begin
              we = 1'b1; swe = 1'b1; swd = val; wd.exited = 1'b1;
              ptr_n = '0; state_next = S_WALK;
            end
          end
          CMD_JOIN: begin
            if (!found) st_n = ST_NOSUCH;
            else if (rd.parent == ID_NONE || target == ID_NONE ||
                     target == ID_BOOT) st_n = ST_INVAL;
            else if (target == caller) st_n = ST_SELF;
            else if (nh) st_n = ST_OK;
            else if (!rd.exited) st_n = ST_PEND;
            else begin
              rpid_n = target; rval_n = rd_st;
            end
          end
          CMD_SETFLAG: begin
            if (!rng(target) || !found) st_n = ST_INVAL;
            else begin
              we = 1'b1; wd.flag = val[7:0];
            end
          end
          CMD_GETFLAG: begin
            if (!rng(target) || !found) st_n = ST_NOSUCH;
            else rval_n = {24'd0, rd.flag};
          end
          default: begin
            if (!rng(target) || !found) st_n = ST_INVAL;
            else state_next = S_RD2;
          end
        endcase
      end
      S_RD2: begin
        ra = slot_of(other); state_next = S_EVAL2;
      end
      S_EVAL2: begin
        if (!rng(other) || !(rd.used && rd.id == other)) st_n = ST_INVAL;
        else rval_n = {31'd0, rd.parent == target};
        state_next = S_OUT;
      end
      S_PROBE: begin
        ra = slot_of(cand); state_next = S_PWAIT;
      end
      S_PWAIT: begin
        wa = slot_of(cand);
        if (!rd.used) begin
          we = 1'b1; swe = 1'b1;
          wd = '0; wd.used = 1'b1; wd.id = cand; wd.parent = caller;
          live_n = live + 1'b1; rpid_n = cand; cand_n = adv(cand);
          state_next = S_OUT;
        end else begin
          cand_n = adv(cand); probes_n = probes + 16'd1;
          if (probes + 16'd1 >= SPAN) begin
            st_n = ST_FULL; state_next = S_OUT;
          end else state_next = S_PROBE;
        end
      end
      S_WALK: begin
        ra = ptr[AW-1:0]; state_next = S_WWAIT;
      end
      S_WWAIT: begin
        wa = ptr[AW-1:0];
        if (rd.used && rng(rd.id) && rd.parent == caller) begin
          we = 1'b1; wd.parent = dk ? ID_NONE : ID_BOOT;
        end
        ptr_n = ptr + 1'b1;
        state_next = (ptr == (AW+1)'(SLOTS - 1)) ? S_WFIN : S_WALK;
      end
      S_WFIN: begin
        ra = slot_of(caller); state_next = S_WFWAIT;
      end
      S_WFWAIT: begin
        wa = slot_of(caller);
        if (rd.parent == ID_NONE) begin
          we = 1'b1; wd = freed; live_n = live - 1'b1;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      cand <= IDF[14:0];
      live <= CW'(1);
    end else begin
      state <= state_next;
      ptr <= ptr_n;
      cand <= cand_n;
      live <= live_n;
    end
    st <= st_n; rpid <= rpid_n; rval <= rval_n; probes <= probes_n;
    if (in_valid && in_ready) begin
      c <= cmd_t'(cmd); caller <= caller_pid; target <= target_pid;
      other <= other_pid; val <= value; dk <= detach_children; nh <= no_hang;
    end
  end

  assign out_valid = state == S_OUT;
  assign status = st;
  assign result_pid = rpid;
  assign result_value = rval;

  a_live: assert property (@(posedge clk) disable iff (rst)
    live <= CW'(SLOTS)) else $error("live count overflow");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_full: assert property (@(posedge clk) disable iff (rst)
    state == S_PWAIT && !rd.used |-> live < CW'(SLOTS))
    else $error("alloc past capacity");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// random and directed command test of the process id table allocator
//------------------------------------------------------------------------------
// Drives command words through the valid/ready input, predicts each result word
// with a behavioral copy of the slot table, and compares results in order.
`default_nettype none
module tb_top;
  import pidt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 128;
  localparam int ID_FIRST = 2;
  localparam int ID_LAST = 32767;

  typedef struct packed {
    logic [2:0]         st;
    logic [14:0]        pid;
    logic signed [31:0] val;
  } result_t;

  class pid_table_scoreboard;
    bit          used[SLOTS];
    bit [14:0]   id[SLOTS];
    bit [14:0]   parent[SLOTS];
    bit          exited[SLOTS];
    bit [31:0]   xstat[SLOTS];
    bit [7:0]    flag[SLOTS];
    int unsigned next_cand;
    int unsigned live;
    result_t     pending_results[$];
    int          errors;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = 0; id[i] = 0; parent[i] = 0; exited[i] = 0; xstat[i] = 0; flag[i] = 0;
      end
      used[ID_BOOT % SLOTS] = 1;
      id[ID_BOOT % SLOTS] = ID_BOOT;
      next_cand = ID_FIRST;
      live = 1;
      errors = 0;
    endfunction

    function bit lookup(bit [14:0] p);
      return used[p % SLOTS] && id[p % SLOTS] == p;
    endfunction

    function bit ranged(bit [14:0] p);
      return p >= ID_FIRST && p <= ID_LAST;
    endfunction

    function void bump();
      next_cand++;
      if (next_cand > ID_LAST) next_cand = ID_FIRST;
    endfunction

    function void release_slot(int s);
      used[s] = 0; id[s] = 0; parent[s] = 0; exited[s] = 0; xstat[s] = 0; flag[s] = 0;
      if (live > 0) live--;
    endfunction

    function void note_command(cmd_t c, bit [14:0] caller, bit [14:0] tgt,
                               bit [14:0] oth, bit [31:0] v, bit dk, bit nh);
      result_t r;
      int s;
      int sc;
      bit got;
      r = '{ST_OK, 15'd0, 32'sd0};
      s = tgt % SLOTS;
      case (c)
        CMD_ALLOC: begin
          got = 0;
          if (live < SLOTS) begin
            for (int i = 0; i < ID_LAST - ID_FIRST + 1; i++) begin
              if (!used[next_cand % SLOTS]) begin
                got = 1;
                break;
              end
              bump();
            end
          end
          if (!got) r.st = ST_FULL;
          else begin
            s = next_cand % SLOTS;
            used[s] = 1; id[s] = next_cand; parent[s] = caller;
            exited[s] = 0; xstat[s] = 0; flag[s] = 0;
            live++;
            r.pid = next_cand;
            bump();
          end
        end
        CMD_UNALLOC: begin
          if (!ranged(tgt)) r.st = ST_INVAL;
          else if (!lookup(tgt)) r.st = ST_NOSUCH;
          else if (exited[s] || parent[s] != caller) r.st = ST_INVAL;
          else release_slot(s);
        end
        CMD_DETACH: begin
          if (!lookup(tgt)) r.st = ST_NOSUCH;
          else if (parent[s] == ID_NONE || parent[s] != caller || tgt == ID_NONE ||
                   tgt == ID_BOOT) r.st = ST_INVAL;
          else if (exited[s]) release_slot(s);
          else parent[s] = ID_NONE;
        end
        CMD_EXIT: begin
          s = caller % SLOTS;
          if (!lookup(caller)) r.st = ST_NOSUCH;
          else begin
            xstat[s] = v;
            exited[s] = 1;
            for (int k = 0; k < SLOTS; k++)
              if (used[k] && ranged(id[k]) && parent[k] == caller)
                parent[k] = dk ? ID_NONE : ID_BOOT;
            if (parent[s] == ID_NONE) release_slot(s);
          end
        end
        CMD_JOIN: begin
          if (!lookup(tgt)) r.st = ST_NOSUCH;
          else if (parent[s] == ID_NONE || tgt == ID_NONE || tgt == ID_BOOT)
            r.st = ST_INVAL;
          else if (tgt == caller) r.st = ST_SELF;
          else if (nh) r.st = ST_OK;
          else if (!exited[s]) r.st = ST_PEND;
          else begin
            r.pid = tgt;
            r.val = xstat[s];
          end
        end
        CMD_SETFLAG: begin
          if (!ranged(tgt) || !lookup(tgt)) r.st = ST_INVAL;
          else flag[s] = v[7:0];
        end
        CMD_GETFLAG: begin
          if (!ranged(tgt) || !lookup(tgt)) r.st = ST_NOSUCH;
          else r.val = {24'd0, flag[s]};
        end
        default: begin
          sc = oth % SLOTS;
          if (!ranged(tgt) || !lookup(tgt) || !ranged(oth) || !lookup(oth))
            r.st = ST_INVAL;
          else r.val = (parent[sc] == tgt) ? 32'sd1 : 32'sd0;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    task check_result(result_t got_r);
      result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      e = pending_results.pop_front();
      if (got_r.st != e.st)
        report_mismatch($sformatf("status %0d, expected %0d", got_r.st, e.st));
      if (got_r.pid != e.pid)
        report_mismatch($sformatf("result_pid %0d, expected %0d", got_r.pid, e.pid));
      if (got_r.val != e.val)
        report_mismatch($sformatf("result_value %0d, expected %0d", got_r.val, e.val));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         cmd = '0;
  logic [14:0]        caller_pid = '0;
  logic [14:0]        target_pid = '0;
  logic [14:0]        other_pid = '0;
  logic signed [31:0] value = '0;
  logic               detach_children = 0;
  logic               no_hang = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [2:0]         status;
  logic [14:0]        result_pid;
  logic signed [31:0] result_value;

  pid_table_scoreboard table_model = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  cycles;
  bit  stim_done;
  bit [14:0] recent_ids[$];

  process_id_table_allocator_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        table_model.check_result('{status, result_pid, result_value});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_command(cmd_t c, bit [14:0] caller, bit [14:0] tgt,
                              bit [14:0] oth, bit [31:0] v, bit dk, bit nh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    caller_pid <= caller;
    target_pid <= tgt;
    other_pid <= oth;
    value <= v;
    detach_children <= dk;
    no_hang <= nh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_model.note_command(c, caller, tgt, oth, v, dk, nh);
    if (c == CMD_ALLOC && table_model.pending_results[$].st == ST_OK)
      recent_ids.push_back(table_model.pending_results[$].pid);
    if (recent_ids.size() > 40) void'(recent_ids.pop_front());
  endtask

  function automatic bit [14:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 70 && recent_ids.size() > 0) return recent_ids[$urandom_range(recent_ids.size() - 1)];
    if (r < 78) return ID_BOOT;
    if (r < 82) return ID_NONE;
    if (r < 86) return 15'h7fff;
    return 15'($urandom);
  endfunction

  task automatic random_command();
    cmd_t c;
    int r;
    r = $urandom_range(99);
    if (r < 22) c = CMD_ALLOC;
    else c = cmd_t'($urandom_range(7));
    send_command(c, pick_id(), pick_id(), pick_id(), $urandom, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    table_model.clear();
    send_idle_pct = 9;
    recv_idle_pct = 83;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed opening
    send_command(CMD_ALLOC, ID_BOOT, 0, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 2, 0, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 2, 0, 0, 0, 0, 0);
    send_command(CMD_SETFLAG, 2, 3, 0, 32'hffff_ffa5, 0, 0);
    send_command(CMD_GETFLAG, 2, 3, 0, 0, 0, 0);
    send_command(CMD_GETFLAG, 2, 15'h7fff, 0, 0, 0, 0);
    send_command(CMD_SETFLAG, 2, 0, 0, 1, 0, 0);
    send_command(CMD_PTEST, 0, 2, 3, 0, 0, 0);
    send_command(CMD_PTEST, 0, 1, 2, 0, 0, 0);
    send_command(CMD_JOIN, 2, 3, 0, 0, 0, 0);
    send_command(CMD_JOIN, 2, 3, 0, 0, 0, 1);
    send_command(CMD_JOIN, 3, 3, 0, 0, 0, 0);
    send_command(CMD_JOIN, 2, ID_BOOT, 0, 0, 0, 0);
    send_command(CMD_EXIT, 3, 0, 0, 32'h8000_0000, 0, 0);
    send_command(CMD_JOIN, 2, 3, 0, 0, 0, 0);
    send_command(CMD_UNALLOC, 2, 3, 0, 0, 0, 0);
    send_command(CMD_DETACH, 2, 3, 0, 0, 0, 0);
    send_command(CMD_DETACH, 1, 2, 0, 0, 0, 0);
    send_command(CMD_DETACH, 1, 2, 0, 0, 0, 0);
    send_command(CMD_EXIT, 2, 0, 0, 32'h7fff_ffff, 1, 0);
    send_command(CMD_UNALLOC, 1, 1, 0, 0, 0, 0);
    send_command(CMD_UNALLOC, 1, 200, 0, 0, 0, 0);
    send_command(CMD_EXIT, 999, 0, 0, 0, 0, 0);
    send_command(CMD_DETACH, 0, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 83;
        recv_idle_pct = 9;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 320; n++) random_command();
      // fill the table once to reach the full case
      if (phase == 1)
        for (int n = 0; n < 140; n++) send_command(CMD_ALLOC, ID_BOOT, 0, 0, 0, 0, 0);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (table_model.pending_results.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (table_model.errors == 0 && table_model.pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
